// ===== hw/rtl/msf_pkg.sv =====
// Package for the median spike filter: widths, reset values, register codes
// and the record that one cell of the sorted window hands to its neighbors.
// No dependencies.
`default_nettype none

package msf_pkg;

  // Width of a pressure sample and of every value held in the window.
  localparam int DATA_W = 24;

  // Default number of samples in the window (legal range 1 to 32).
  localparam int WINDOW_DEF = 5;

  // Age counter width, sized for the largest legal window.
  localparam int AGE_W = 5;

  // Configuration port geometry: 32-bit data, one register at byte address 0.
  localparam int PDATA_W = 32;
  localparam int PADDR_W = 3;
  localparam int REG_IDX_W = PADDR_W - 2;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_SPIKE_THRESHOLD = 1'b0;

  // Reset value of the spike threshold.
  localparam logic [DATA_W-1:0] THRESHOLD_RESET = 24'd100000;

  // What one cell shows its neighbors: its value, the age of that value and
  // whether the value is greater than the sample now being inserted.
  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic [AGE_W-1:0]  age;
    logic              gt;
  } cell_view_t;

endpackage

`default_nettype wire

// ===== hw/rtl/msf_cell.sv =====
// One cell of the sorted window: holds one sample and its age, and on every
// accepted beat drops the oldest entry and inserts the new one in order.
// Depends on msf_pkg.
`default_nettype none

module msf_cell #(
  parameter int WINDOW = msf_pkg::WINDOW_DEF,
  parameter int INDEX  = 0
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       load,
  input  wire logic [msf_pkg::DATA_W-1:0] sample,
  input  wire msf_pkg::cell_view_t        left,
  input  wire msf_pkg::cell_view_t        right,
  input  wire logic                       oldest_below_in,
  output logic                            oldest_below_out,
  output msf_pkg::cell_view_t             view
);

  localparam bit HAS_LEFT  = (INDEX > 0);
  localparam bit HAS_RIGHT = (INDEX < WINDOW - 1);
  localparam logic [msf_pkg::AGE_W-1:0] AGE_MAX   = msf_pkg::AGE_W'(WINDOW - 1);
  localparam logic [msf_pkg::AGE_W-1:0] AGE_RESET = msf_pkg::AGE_W'(WINDOW - 1 - INDEX);

  logic [msf_pkg::DATA_W-1:0] val;
  logic [msf_pkg::DATA_W-1:0] val_next;
  logic [msf_pkg::AGE_W-1:0]  age;
  logic [msf_pkg::AGE_W-1:0]  age_next;
  logic                       oldest_here;
  msf_pkg::cell_view_t        rem_here;
  msf_pkg::cell_view_t        rem_left;

  assign view = '{val: val, age: age, gt: (val > sample)};

  // The oldest entry leaves the list; everything above it slides down one.
  assign oldest_here      = (age == AGE_MAX);
  assign oldest_below_out = oldest_below_in | oldest_here;

  // Entries of the list with the oldest removed, at this place and one below.
  assign rem_here = oldest_below_out ? right : view;
  assign rem_left = oldest_below_in  ? view  : left;

  always_comb begin
    priority if (HAS_RIGHT && !rem_here.gt) begin
      val_next = rem_here.val;
      age_next = rem_here.age + msf_pkg::AGE_W'(1);
    end else if (HAS_LEFT && rem_left.gt) begin
      val_next = rem_left.val;
      age_next = rem_left.age + msf_pkg::AGE_W'(1);
    end else begin
      val_next = sample;
      age_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val <= '0;
      age <= AGE_RESET;
    end else if (load) begin
      val <= val_next;
      age <= age_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/msf_spike.sv =====
// Median and spike decision stages: averages the two middle taps of the
// window, then compares the distance to the threshold. Depends on msf_pkg.
`default_nettype none

module msf_spike (
  input  wire logic                       clk,
  input  wire logic                       advance,
  input  wire logic [msf_pkg::DATA_W-1:0] sample,
  input  wire logic [msf_pkg::DATA_W-1:0] mid_lo,
  input  wire logic [msf_pkg::DATA_W-1:0] mid_hi,
  input  wire logic [msf_pkg::DATA_W-1:0] threshold,
  output logic      [msf_pkg::DATA_W-1:0] cleaned,
  output logic      [msf_pkg::DATA_W-1:0] median,
  output logic                            spike
);

  logic [msf_pkg::DATA_W:0]   mid_sum;
  logic [msf_pkg::DATA_W-1:0] med_s2;
  logic [msf_pkg::DATA_W-1:0] smp_s2;
  logic [msf_pkg::DATA_W-1:0] distance;
  logic                       spike_next;

  // For an odd window both taps are the middle cell, so the average is exact.
  assign mid_sum = {1'b0, mid_lo} + {1'b0, mid_hi};

  assign distance   = (med_s2 > smp_s2) ? (med_s2 - smp_s2) : (smp_s2 - med_s2);
  assign spike_next = (distance > threshold);

  always_ff @(posedge clk) begin
    if (advance) begin
      med_s2  <= mid_sum[msf_pkg::DATA_W:1];
      smp_s2  <= sample;
      median  <= med_s2;
      spike   <= spike_next;
      cleaned <= spike_next ? med_s2 : smp_s2;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/median_spike_filter.sv =====
// Top level of the median spike filter: configuration register, the chain of
// sorted window cells and the three-stage result pipeline.
// Depends on msf_pkg, msf_cell and msf_spike.
//
// Usage:
//   Samples enter on the sample channel (sample_valid / sample_ready) and one
//   result beat leaves on the result channel (result_valid / result_ready)
//   for each sample, carrying cleaned, median and spike.
//   The window is a row of WINDOW cells kept in ascending order. Each cell
//   tracks the age of its value; on an accepted beat the oldest entry drops
//   out and the new sample is slotted in, all cells updating together.
//   From the accepting edge a beat passes valid_s1 and valid_s2 before
//   result_valid rises. The block takes one beat per cycle while no result
//   is stalled; the whole cell row is updated at once on each insert.
//   Reset clears the window to zeros (so the first medians count those zeros),
//   loads the threshold with 100000 and empties the pipeline.
//   When the receiver holds result_ready low with a result pending, the whole
//   pipeline and the window freeze and sample_ready drops until it is taken.
//   The threshold is written through the APB-style port at byte address 0.
//   A distance equal to the threshold is not a spike.
`default_nettype none

module median_spike_filter #(
  parameter int WINDOW = msf_pkg::WINDOW_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Configuration port.
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [msf_pkg::PADDR_W-1:0] paddr,
  input  wire logic [msf_pkg::PDATA_W-1:0] pwdata,
  output logic      [msf_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  // Sample channel.
  input  wire logic                        sample_valid,
  output logic                             sample_ready,
  input  wire logic [msf_pkg::DATA_W-1:0]  sample,
  // Result channel.
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output logic      [msf_pkg::DATA_W-1:0]  cleaned,
  output logic      [msf_pkg::DATA_W-1:0]  median,
  output logic                             spike
);

  localparam int MID_LO = (WINDOW - 1) / 2;
  localparam int MID_HI = WINDOW / 2;

  logic [msf_pkg::DATA_W-1:0]    threshold;
  logic [msf_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          reg_write;

  logic                          advance;
  logic                          accept;
  logic                          valid_s1;
  logic                          valid_s2;
  logic [msf_pkg::DATA_W-1:0]    sample_s1;

  msf_pkg::cell_view_t           views [WINDOW];
  logic [WINDOW:0]               oldest_below;

  // ---------------------------------------------------------------------------
  // Configuration register. The port never waits; reads return the threshold
  // and zero for any unused address.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = paddr[msf_pkg::PADDR_W-1:2];
  assign reg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= msf_pkg::THRESHOLD_RESET;
    end else if (reg_write) begin
      unique case (reg_idx)
        msf_pkg::REG_SPIKE_THRESHOLD: threshold <= pwdata[msf_pkg::DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      msf_pkg::REG_SPIKE_THRESHOLD: begin
        prdata = {{(msf_pkg::PDATA_W - msf_pkg::DATA_W){1'b0}}, threshold};
      end
      default: prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Everything moves together unless a finished result is
  // waiting on a stalled receiver.
  // ---------------------------------------------------------------------------
  assign advance      = !result_valid || result_ready;
  assign sample_ready = advance;
  assign accept       = sample_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1     <= 1'b0;
      valid_s2     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      valid_s1     <= sample_valid;
      valid_s2     <= valid_s1;
      result_valid <= valid_s2;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_s1 <= sample;
    end
  end

  // ---------------------------------------------------------------------------
  // Sorted window. Cell 0 holds the smallest value. The oldest-entry flag
  // ripples upward so each cell knows whether the leaving entry sits below it.
  // ---------------------------------------------------------------------------
  assign oldest_below[0] = 1'b0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    msf_pkg::cell_view_t left_view;
    msf_pkg::cell_view_t right_view;

    if (i > 0) begin : g_left
      assign left_view = views[i-1];
    end else begin : g_no_left
      assign left_view = '0;
    end

    if (i < WINDOW - 1) begin : g_right
      assign right_view = views[i+1];
    end else begin : g_no_right
      assign right_view = '0;
    end

    msf_cell #(
      .WINDOW (WINDOW),
      .INDEX  (i)
    ) u_cell (
      .clk              (clk),
      .rst              (rst),
      .load             (accept),
      .sample           (sample),
      .left             (left_view),
      .right            (right_view),
      .oldest_below_in  (oldest_below[i]),
      .oldest_below_out (oldest_below[i+1]),
      .view             (views[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Median and spike decision. The middle cells are read into med_s2 after the
  // insert, while the next sample may already be going into the window.
  // ---------------------------------------------------------------------------
  msf_spike u_spike (
    .clk       (clk),
    .advance   (advance),
    .sample    (sample_s1),
    .mid_lo    (views[MID_LO].val),
    .mid_hi    (views[MID_HI].val),
    .threshold (threshold),
    .cleaned   (cleaned),
    .median    (median),
    .spike     (spike)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/msf_checker.sv =====
// Port-level checks for the median spike filter, bound to its top level.
// Depends on msf_pkg.
`default_nettype none

module msf_props (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       pready,
  input wire logic                       sample_ready,
  input wire logic                       result_valid,
  input wire logic                       result_ready,
  input wire logic [msf_pkg::DATA_W-1:0] cleaned,
  input wire logic [msf_pkg::DATA_W-1:0] median,
  input wire logic                       spike
);

  // A replaced sample must come out as the median itself.
  a_spike_takes_median: assert property (@(posedge clk) disable iff (rst)
    result_valid && spike |-> cleaned == median)
    else $error("spike set but cleaned differs from median");

  // A stalled result freezes the pipeline, so no new sample may enter.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !sample_ready)
    else $error("sample accepted while a result is stalled");

  // A stalled result beat holds its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(cleaned) && $stable(median) && $stable(spike))
    else $error("stalled result changed");

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid && pready)
    else $error("result valid right after reset");

endmodule

bind median_spike_filter msf_props u_msf_props (.*);

`default_nettype wire

// ===== verif/msf_checker.sv =====
// Checker for the median spike filter: tracks threshold writes and sample beats,
// predicts each result beat and compares it with what the filter produces.
// Depends on msf_pkg for widths, the register index and the threshold reset value.
module msf_checker #(
  parameter int WINDOW = msf_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [msf_pkg::PADDR_W-1:0] paddr,
  input  logic [msf_pkg::PDATA_W-1:0] pwdata,
  input  logic                        sample_valid,
  input  logic                        sample_ready,
  input  logic [msf_pkg::DATA_W-1:0]  sample,
  input  logic                        result_valid,
  input  logic                        result_ready,
  input  logic [msf_pkg::DATA_W-1:0]  cleaned,
  input  logic [msf_pkg::DATA_W-1:0]  median,
  input  logic                        spike,
  output int                          in_flight,
  output int                          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import msf_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] cleaned;
    logic [DATA_W-1:0] median;
    logic              spike;
  } filtered_t;

  logic [DATA_W-1:0] threshold;
  logic [DATA_W-1:0] ring [WINDOW];
  int                slot;
  filtered_t         filtered_q[$];
  int                misses = 0;
  int                results_seen = 0;

  assign fail_count = misses;

  // Middle of the sorted window; an even window averages the two middle values.
  function automatic logic [DATA_W-1:0] window_middle();
    logic [DATA_W-1:0] ordered [WINDOW];
    logic [DATA_W-1:0] v;
    logic [DATA_W:0]   pair;
    int                i;
    int                k;
    for (i = 0; i < WINDOW; i++) begin
      v = ring[i];
      k = i;
      while (k > 0 && ordered[k-1] > v) begin
        ordered[k] = ordered[k-1];
        k--;
      end
      ordered[k] = v;
    end
    if (WINDOW % 2 == 0) begin
      pair = ordered[WINDOW/2-1] + ordered[WINDOW/2];
      return pair[DATA_W:1];
    end
    return ordered[WINDOW/2];
  endfunction

  // Insert one sample into the ring and work out the filtered beat it causes.
  function automatic filtered_t filter_step(input logic [DATA_W-1:0] s);
    filtered_t         r;
    logic [DATA_W-1:0] mid;
    logic [DATA_W-1:0] distance;
    if (slot >= WINDOW) slot = 0;
    ring[slot] = s;
    slot++;
    if (slot >= WINDOW) slot = 0;
    mid = window_middle();
    distance = (mid > s) ? mid - s : s - mid;
    r.spike = distance > threshold;
    r.median = mid;
    r.cleaned = r.spike ? mid : s;
    return r;
  endfunction

  task automatic note_miss(input filtered_t want, input filtered_t got, input bit orphan);
    misses++;
    if (misses <= 10) begin
      if (orphan) begin
        $display({"msf_checker: result %0d arrived with no sample pending: ",
                  "cleaned %h median %h spike %b"},
                 results_seen, got.cleaned, got.median, got.spike);
      end else begin
        $display({"msf_checker: result %0d expected cleaned %h median %h spike %b, ",
                  "got %h %h %b"},
                 results_seen, want.cleaned, want.median, want.spike,
                 got.cleaned, got.median, got.spike);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    filtered_t got;
    filtered_t want;
    if (rst) begin
      threshold = THRESHOLD_RESET;
      for (int i = 0; i < WINDOW; i++) ring[i] = '0;
      slot = 0;
      filtered_q.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[PADDR_W-1:2] == REG_SPIKE_THRESHOLD) begin
        threshold = pwdata[DATA_W-1:0];
      end
      // The result side is looked at before the new sample is queued, so a
      // result can never be matched against a sample taken at the same edge.
      if (result_valid && result_ready) begin
        got = '{cleaned: cleaned, median: median, spike: spike};
        if (filtered_q.size() == 0) begin
          note_miss(got, got, 1'b1);
        end else begin
          want = filtered_q.pop_front();
          if (got.cleaned !== want.cleaned || got.median !== want.median ||
              got.spike !== want.spike) begin
            note_miss(want, got, 1'b0);
          end
        end
        results_seen++;
      end
      if (sample_valid && sample_ready) filtered_q.push_back(filter_step(sample));
    end
    in_flight <= filtered_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the median spike filter testbench: clock, reset, stimulus on the
// sample channel and the threshold register, random stalls on the result side.
// Depends on msf_pkg, median_spike_filter and msf_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import msf_pkg::*;

  // Register index that decodes to nothing; writes to it must be ignored.
  localparam logic [REG_IDX_W-1:0] REG_NONE = 1'b1;
  localparam int WIN = WINDOW_DEF;
  localparam int LEVEL_MAX = 24'hFFFFFF;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                sample_valid = 1'b0;
  logic                sample_ready;
  logic [DATA_W-1:0]   sample = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic [DATA_W-1:0]   cleaned;
  logic [DATA_W-1:0]   median;
  logic                spike;
  int                  in_flight;
  int                  fail_count;

  // When set, neither the sample sender nor the result receiver idles.
  bit                  no_idle = 1'b0;

  always #5 clk = ~clk;

  median_spike_filter #(.WINDOW(WIN)) uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
    .result_valid(result_valid), .result_ready(result_ready),
    .cleaned(cleaned), .median(median), .spike(spike)
  );

  msf_checker #(.WINDOW(WIN)) watch (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
    .result_valid(result_valid), .result_ready(result_ready),
    .cleaned(cleaned), .median(median), .spike(spike),
    .in_flight(in_flight), .fail_count(fail_count)
  );

  // The receiver stalls roughly 30 percent of the time. The stall is
  // picked per cycle, so it lands on every stage of the result pipeline and
  // the freeze of the window behind it gets exercised at every phase.
  always @(posedge clk) begin
    result_ready <= no_idle || ($urandom_range(99) >= 30);
  end

  // Offer one sample beat and return at the edge where it is taken. Valid is
  // raised without looking at ready and stays up until the handshake; it is
  // only dropped here when an idle gap is wanted before this beat.
  task automatic send_sample(input logic [DATA_W-1:0] v);
    int gap;
    if (!no_idle && $urandom_range(99) < 20) begin
      gap = $urandom_range(3, 1);
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= v;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge
  // that ends the access cycle, since pready is always high.
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Stop offering samples and wait until every result beat has been taken.
  // The first edge is always spent so that the checker has seen the last
  // sample beat before its in-flight count is trusted.
  task automatic settle();
    int n;
    n = 0;
    sample_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
  endtask

  // Synthetic pressure trace. Most readings follow a slowly drifting level
  // with a little noise, some sit right at the threshold distance from that
  // level, some are large spikes, and a few are anywhere in the full range.
  function automatic logic [DATA_W-1:0] next_reading(inout int level, input int limit);
    int kind;
    int val;
    kind = $urandom_range(99);
    level = level + int'($urandom_range(400)) - 200;
    if (kind < 55) begin
      val = level + int'($urandom_range(1000)) - 500;
    end else if (kind < 70) begin
      val = limit + int'($urandom_range(2)) - 1;
      val = $urandom_range(1) ? level + val : level - val;
    end else if (kind < 85) begin
      val = int'($urandom_range(4000000));
      val = $urandom_range(1) ? level + val : level - val;
    end else if (kind < 95) begin
      val = int'($urandom_range(LEVEL_MAX));
      if ($urandom_range(3) == 0) level = val;
    end else begin
      val = $urandom_range(1) ? LEVEL_MAX : 0;
    end
    if (level < 0) level = 0;
    if (level > LEVEL_MAX) level = LEVEL_MAX;
    if (val < 0) val = 0;
    if (val > LEVEL_MAX) val = LEVEL_MAX;
    return val[DATA_W-1:0];
  endfunction

  initial begin
    int                level;
    int                limit;
    int                phase;
    int                i;
    logic [DATA_W-1:0] thr;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, first under the reset threshold of 100000. The window
    // is still all zeros, so the median of the first beats is zero: a sample
    // exactly 100000 away is not a spike, one more than that is.
    send_sample(24'd100000);
    send_sample(24'd100001);
    send_sample(24'hFFFFFF);
    send_sample(24'h000000);
    send_sample(24'h000000);
    for (i = 0; i < WIN; i++) send_sample(24'hFFFFFF);
    // A lone zero inside a full-scale window is replaced by the median.
    send_sample(24'h000000);
    send_sample(24'h555555);
    send_sample(24'hAAAAAA);
    send_sample(24'h800000);
    send_sample(24'h7FFFFF);

    // Zero threshold: only an exact match with the median passes through.
    settle();
    reg_write(REG_SPIKE_THRESHOLD, 32'd0);
    for (i = 0; i < WIN; i++) send_sample(24'd1234);
    send_sample(24'd1235);

    // Full-scale threshold: nothing can ever be flagged.
    settle();
    reg_write(REG_SPIKE_THRESHOLD, {8'hA5, 24'hFFFFFF});
    send_sample(24'h000000);
    send_sample(24'hFFFFFF);

    // A write to an index with no register behind it must leave the
    // full-scale threshold in place.
    settle();
    reg_write(REG_NONE, 32'd0);
    send_sample(24'h000000);

    // Random part: six phases of 250 beats, each under its own threshold.
    // Phase two runs with no idling on either side.
    level = int'($urandom_range(LEVEL_MAX));
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: thr = 24'd100;
        1: thr = 24'd2000;
        2: thr = THRESHOLD_RESET;
        3: thr = DATA_W'($urandom_range(LEVEL_MAX));
        4: thr = 24'd0;
        default: thr = 24'hFFFFFF;
      endcase
      settle();
      reg_write(REG_SPIKE_THRESHOLD, {8'($urandom_range(255)), thr});
      limit = int'(thr);
      no_idle = (phase == 2);
      for (i = 0; i < 250; i++) send_sample(next_reading(level, limit));
    end
    no_idle = 1'b0;

    // Drain: wait for the last result beat, then keep watching the pipeline
    // so that any stray extra beat would still be caught.
    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && in_flight == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/msf_pkg.sv
hw/rtl/msf_cell.sv
hw/rtl/msf_spike.sv
hw/rtl/median_spike_filter.sv
hw/rtl/msf_checker.sv
verif/msf_checker.sv
verif/tb_top.sv
